>>> rtl/core/qec_pkg.sv
`timescale 1ns / 1ps
package qec_pkg;

  // Pin states, bit 0 = line A asserted, bit 1 = line B asserted
  localparam logic [1:0] ROLL_IDLE   = 2'h0;
  localparam logic [1:0] ROLL_A_ONLY = 2'h1;
  localparam logic [1:0] ROLL_B_ONLY = 2'h2;
  localparam logic [1:0] ROLL_BOTH   = 2'h3;

  // Bit positions in the detent edge flags
  localparam int FLG_FIRST_FWD = 0;
  localparam int FLG_FIRST_BWD = 1;
  localparam int FLG_LAST_FWD  = 2;
  localparam int FLG_LAST_BWD  = 3;
  localparam int FLG_MIDDLE    = 4;
  localparam int FLAG_W        = 5;

  // Step and direction codes, two's complement
  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_FWD  = 2'sb01;
  localparam logic signed [1:0] STEP_BWD  = 2'sb11;

  // Decode modes
  localparam logic MODE_EDGE   = 1'b0;
  localparam logic MODE_DETENT = 1'b1;

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'd1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic signed [1:0]  step;
    logic [FLAG_W-1:0]  flags;
  } dec_out_t;

endpackage

>>> rtl/core/qec_if.sv
`timescale 1ns / 1ps
interface qec_sample_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic ms_tick;
  logic clear_count;
  logic clear_moved;

  modport source (output valid, pin_a, pin_b, ms_tick, clear_count, clear_moved,
                  input ready);
  modport sink (input valid, pin_a, pin_b, ms_tick, clear_count, clear_moved,
                output ready);
endinterface

interface qec_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] count;
  logic               moved;
  logic signed [1:0]  step;
  logic [31:0]        last_move_ms;

  modport source (output valid, count, moved, step, last_move_ms, input ready);
  modport sink (input valid, count, moved, step, last_move_ms, output ready);
endinterface

>>> rtl/core/qec_decode.sv
`timescale 1ns / 1ps
// Transition decoder: works out the step for a change of pin state and the
// detent edge flags that follow it. Only meaningful when the pins changed.
module qec_decode (
  input  logic                      mode,
  input  logic [1:0]                prev,
  input  logic [1:0]                cur,
  input  logic [qec_pkg::FLAG_W-1:0] flags,
  input  logic signed [1:0]         last_dir,
  output qec_pkg::dec_out_t         dec
);
  import qec_pkg::*;

  logic signed [1:0] edge_step;
  logic signed [1:0] det_step;
  logic [FLAG_W-1:0] f;
  logic [FLAG_W-1:0] det_flags;

  // Edge mode: a skipped state repeats the remembered direction.
  always_comb begin
    edge_step = last_dir;
    case (cur)
      ROLL_IDLE: begin
        if (prev == ROLL_B_ONLY) edge_step = STEP_FWD;
        else if (prev == ROLL_A_ONLY) edge_step = STEP_BWD;
      end
      ROLL_A_ONLY: begin
        if (prev == ROLL_IDLE) edge_step = STEP_FWD;
        else if (prev == ROLL_BOTH) edge_step = STEP_BWD;
      end
      ROLL_B_ONLY: begin
        if (prev == ROLL_BOTH) edge_step = STEP_FWD;
        else if (prev == ROLL_IDLE) edge_step = STEP_BWD;
      end
      default: begin
        if (prev == ROLL_A_ONLY) edge_step = STEP_FWD;
        else if (prev == ROLL_B_ONLY) edge_step = STEP_BWD;
      end
    endcase
  end

  // Detent mode: gather flags, judge them when the lines fall back to idle.
  always_comb begin
    f = flags;
    det_step = STEP_NONE;
    if (prev == ROLL_IDLE) begin
      if (cur == ROLL_A_ONLY) f[FLG_FIRST_FWD] = 1'b1;
      else if (cur == ROLL_B_ONLY) f[FLG_FIRST_BWD] = 1'b1;
    end
    if (cur == ROLL_BOTH) begin
      f[FLG_MIDDLE] = 1'b1;
    end else if (cur == ROLL_IDLE) begin
      if (prev == ROLL_B_ONLY) f[FLG_LAST_FWD] = 1'b1;
      else if (prev == ROLL_A_ONLY) f[FLG_LAST_BWD] = 1'b1;
    end
    if (f[FLG_FIRST_FWD] && (f[FLG_LAST_FWD] || f[FLG_MIDDLE])) det_step = STEP_FWD;
    else if (f[FLG_LAST_FWD] && (f[FLG_FIRST_FWD] || f[FLG_MIDDLE])) det_step = STEP_FWD;
    else if (f[FLG_FIRST_BWD] && (f[FLG_LAST_BWD] || f[FLG_MIDDLE])) det_step = STEP_BWD;
    else if (f[FLG_LAST_BWD] && (f[FLG_FIRST_BWD] || f[FLG_MIDDLE])) det_step = STEP_BWD;
    det_flags = f;
    if (cur == ROLL_IDLE) begin
      det_flags = '0;
    end else begin
      det_step = STEP_NONE;
    end
  end

  always_comb begin
    if (mode == MODE_DETENT) begin
      dec.step  = det_step;
      dec.flags = det_flags;
    end else begin
      dec.step  = edge_step;
      dec.flags = flags;
    end
  end

endmodule

>>> rtl/core/quadrature_encoder_counter.sv
`timescale 1ns / 1ps
// Quadrature encoder counter. Each sample word carries the two active-low
// encoder lines, a millisecond tick and two clear requests; each accepted
// sample gives exactly one result word with the signed wrapping position
// count, the sticky moved flag (both as they stand before any clear asked
// for by that sample), the step taken (+1, -1 or 0) and the millisecond
// time of the latest counted step. A tick advances the millisecond clock
// before the sample is decoded. The block takes one sample every clock cycle
// unless results stall, and each result appears in the cycle after its sample:
// the decoder state and the result register are updated in the same cycle
// the sample is accepted, and the result register lets a new sample in while
// the previous result is being taken. There is no clearing pass after reset.
// The user must write configuration registers (decode_mode at index 0,
// direction_timeout_ms at index 1) only while the block is idle; not enforced.
module quadrature_encoder_counter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [qec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qec_pkg::CFG_DATA_W-1:0]   cfg_data,
  qec_sample_if.sink                       samples,
  qec_result_if.source                     results
);
  import qec_pkg::*;

  // Configuration
  logic        decode_mode;
  logic [15:0] timeout_ms;

  // Decoder state
  logic signed [31:0] position;
  logic [1:0]         prev_pins;
  logic [FLAG_W-1:0]  edge_flags;
  logic signed [1:0]  last_dir;
  logic               moved_flag;
  logic [31:0]        last_move_time;
  logic [31:0]        ms_clock;
  // Milliseconds since the last counted step; always equals
  // ms_clock - last_move_time, kept so the timeout is one add and compare.
  logic [31:0]        elapsed;

  // Result register
  logic               out_valid;
  logic signed [31:0] out_count;
  logic               out_moved;
  logic signed [1:0]  out_step;
  logic [31:0]        out_time;

  logic               fire;
  logic [1:0]         cur_pins;
  logic               pins_changed;
  dec_out_t           dec;
  logic signed [1:0]  step_taken;
  logic [31:0]        ms_clock_next;
  logic [31:0]        elapsed_next;
  logic signed [31:0] position_next;
  logic               moved_next;
  logic [31:0]        last_move_time_next;

  assign samples.ready = !out_valid || results.ready;
  assign fire = samples.valid && samples.ready;

  assign cur_pins     = {~samples.pin_b, ~samples.pin_a};
  assign pins_changed = (cur_pins != prev_pins);

  qec_decode u_decode (
    .mode     (decode_mode),
    .prev     (prev_pins),
    .cur      (cur_pins),
    .flags    (edge_flags),
    .last_dir (last_dir),
    .dec      (dec)
  );

  assign step_taken = pins_changed ? dec.step : STEP_NONE;

  always_comb begin
    ms_clock_next       = ms_clock + {31'd0, samples.ms_tick};
    elapsed_next        = elapsed + {31'd0, samples.ms_tick};
    position_next       = position;
    moved_next          = moved_flag;
    last_move_time_next = last_move_time;
    if (step_taken != STEP_NONE) begin
      position_next       = position + {{30{step_taken[1]}}, step_taken};
      moved_next          = 1'b1;
      last_move_time_next = ms_clock_next;
      elapsed_next        = '0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= MODE_EDGE;
      timeout_ms  <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECODE_MODE: decode_mode <= cfg_data[0];
        CFG_TIMEOUT:     timeout_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state update on every accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      prev_pins      <= ROLL_IDLE;
      edge_flags     <= '0;
      last_dir       <= STEP_NONE;
      moved_flag     <= 1'b0;
      last_move_time <= '0;
      ms_clock       <= '0;
      elapsed        <= '0;
    end else if (fire) begin
      ms_clock       <= ms_clock_next;
      elapsed        <= elapsed_next;
      last_move_time <= last_move_time_next;
      position       <= samples.clear_count ? '0 : position_next;
      moved_flag     <= samples.clear_moved ? 1'b0 : moved_next;
      if (pins_changed) begin
        prev_pins  <= cur_pins;
        edge_flags <= dec.flags;
        if (step_taken != STEP_NONE) begin
          last_dir <= step_taken;
        end
      end else if (elapsed_next >= {16'd0, timeout_ms}) begin
        // Lines idle long enough: forget the direction used for skips.
        last_dir <= STEP_NONE;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_count <= position_next;
      out_moved <= moved_next;
      out_step  <= step_taken;
      out_time  <= last_move_time_next;
    end
  end

  assign results.valid        = out_valid;
  assign results.count        = out_count;
  assign results.moved        = out_moved;
  assign results.step         = out_step;
  assign results.last_move_ms = out_time;

  // A reported step always comes with the moved flag set.
  a_step_sets_moved: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.step != STEP_NONE) |-> results.moved)
    else $error("step reported without moved flag");

  // The elapsed counter tracks the clock minus the time of the last step.
  a_elapsed_consistent: assert property (@(posedge clk) disable iff (rst)
    elapsed == ms_clock - last_move_time)
    else $error("elapsed time out of step with millisecond clock");

  // A clear request empties the count after the word is reported.
  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    (fire && samples.clear_count) |=> (position == 32'sd0))
    else $error("count not cleared");

  // A counted step stamps the result with the current millisecond time.
  a_step_stamp: assert property (@(posedge clk) disable iff (rst)
    (fire && step_taken != STEP_NONE) |=> (out_time == ms_clock))
    else $error("step not stamped with current time");

  // The remembered direction never takes the unused code.
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    last_dir != 2'sb10)
    else $error("bad direction code");

endmodule
